// ===== src/munsell_grid_to_xy_interp_unit_assert.svh =====
// Assertion macros shared by the grid interpolation unit
`ifndef MUNSELL_GRID_TO_XY_INTERP_UNIT_ASSERT_SVH
`define MUNSELL_GRID_TO_XY_INTERP_UNIT_ASSERT_SVH

// Check that cons holds in the cycle after ante
`define MGXY_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that cons holds in the same cycle as ante
`define MGXY_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/mgxy_pkg.sv =====
// Shared constants, codes and types of the grid interpolation unit
package mgxy_pkg;

    // default grid size
    localparam int HUE_STEPS_DEF    = 40;
    localparam int CHROMA_STEPS_DEF = 21;

    // field widths
    localparam int CMD_W      = 1;
    localparam int LD_HUE_W   = 6;
    localparam int LD_CHR_W   = 5;
    localparam int FRAC_W     = 16;
    localparam int ENTRY_W    = 2 * FRAC_W;
    localparam int WGT_W      = FRAC_W + 1;
    localparam int PROD_W     = WGT_W + FRAC_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = ENTRY_W;

    // rounding offset: one half of the u0.16 step
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
    // unit weight in u1.16
    localparam logic [WGT_W-1:0] WGT_ONE    = WGT_W'(1) << FRAC_W;

    // item kinds carried on tuser
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CONV = 1'b1;

    // control of the word held after the index stage
    typedef struct packed {
        logic valid;
        logic load;
        logic in_range;
        logic lower;
    } t_s1_ctl;

endpackage

// ===== src/mgxy_grid_ram.sv =====
// Grid memory: one write port, two registered read ports
module mgxy_grid_ram #(
    parameter int DEPTH = 840,
    parameter int AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [mgxy_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output logic [mgxy_pkg::ENTRY_W-1:0] o_rdata_a,
    output logic [mgxy_pkg::ENTRY_W-1:0] o_rdata_b
);
    import mgxy_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read two entries, hold data while stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== src/mgxy_index.sv =====
// Input stage: scale hue and chroma to cell corners and triangle weights
module mgxy_index #(
    parameter int HUE_STEPS    = 40,
    parameter int CHROMA_STEPS = 21,
    parameter int HW           = 6,
    parameter int CW           = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mgxy_pkg::CMD_W-1:0]    i_cmd,
    input  logic [mgxy_pkg::LD_HUE_W-1:0] i_load_hue_index,
    input  logic [mgxy_pkg::LD_CHR_W-1:0] i_load_chroma_index,
    input  logic [mgxy_pkg::FRAC_W-1:0]   i_load_x,
    input  logic [mgxy_pkg::FRAC_W-1:0]   i_load_y,
    input  logic [mgxy_pkg::FRAC_W-1:0]   i_hue,
    input  logic [mgxy_pkg::FRAC_W-1:0]   i_chroma,
    input  logic                          i_ready,
    output mgxy_pkg::t_s1_ctl             o_ctl,
    output logic [HW-1:0]                 o_h0,
    output logic [HW-1:0]                 o_h1,
    output logic [CW-1:0]                 o_c0,
    output logic [CW-1:0]                 o_c1,
    output logic [mgxy_pkg::WGT_W-1:0]    o_w0,
    output logic [mgxy_pkg::WGT_W-1:0]    o_wm,
    output logic [mgxy_pkg::WGT_W-1:0]    o_w2,
    output logic [mgxy_pkg::ENTRY_W-1:0]  o_wdata
);
    import mgxy_pkg::*;

    localparam int HSW = FRAC_W + HW;
    localparam int CSW = FRAC_W + CW;

    logic [HSW-1:0]    w_hs;
    logic [CSW-1:0]    w_cs;
    logic [HW-1:0]     w_h0;
    logic [HW-1:0]     w_h1;
    logic [CW-1:0]     w_c0;
    logic [CW-1:0]     w_c1;
    logic [FRAC_W-1:0] w_hu;
    logic [FRAC_W-1:0] w_cu;
    logic              w_lower;
    logic [31:0]       w_lh;
    logic [31:0]       w_lc;
    logic              w_in_range;
    logic              w_load;
    logic              w_adv;

    t_s1_ctl            r_ctl;
    logic [HW-1:0]      r_h0;
    logic [HW-1:0]      r_h1;
    logic [CW-1:0]      r_c0;
    logic [CW-1:0]      r_c1;
    logic [WGT_W-1:0]   r_w0;
    logic [WGT_W-1:0]   r_wm;
    logic [WGT_W-1:0]   r_w2;
    logic [ENTRY_W-1:0] r_wdata;

    // advance when the stage is empty or drains this cycle
    assign w_adv   = !r_ctl.valid || i_ready;
    assign o_ready = w_adv;
    assign w_load  = (i_cmd == CMD_LOAD);

    // scale to integer corner and fraction
    assign w_hs = HSW'(i_hue) * HSW'(HUE_STEPS);
    assign w_cs = CSW'(i_chroma) * CSW'(CHROMA_STEPS);
    assign w_hu = w_hs[FRAC_W-1:0];
    assign w_cu = w_cs[FRAC_W-1:0];

    // wrap hue, clamp chroma; load items use their own row and column
    assign w_lh = 32'(i_load_hue_index);
    assign w_lc = 32'(i_load_chroma_index);
    assign w_in_range = (w_lh < 32'(HUE_STEPS)) && (w_lc < 32'(CHROMA_STEPS));

    always_comb begin
        if (w_load) begin
            w_h0 = w_lh[HW-1:0];
            w_c0 = w_lc[CW-1:0];
        end else begin
            w_h0 = w_hs[FRAC_W +: HW];
            w_c0 = w_cs[FRAC_W +: CW];
        end
        w_h1 = (w_h0 == HW'(HUE_STEPS - 1))    ? '0   : w_h0 + HW'(1);
        w_c1 = (w_c0 == CW'(CHROMA_STEPS - 1)) ? w_c0 : w_c0 + CW'(1);
    end

    // pick the triangle: lower when the hue fraction is not below chroma
    assign w_lower = (w_hu >= w_cu);

    // hold control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (w_adv) begin
            r_ctl.valid    <= i_valid;
            r_ctl.load     <= w_load;
            r_ctl.in_range <= w_in_range;
            r_ctl.lower    <= w_lower;
        end
    end

    // hold payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h0    <= w_h0;
            r_h1    <= w_h1;
            r_c0    <= w_c0;
            r_c1    <= w_c1;
            r_wdata <= {i_load_y, i_load_x};
            if (w_lower) begin
                r_w0 <= WGT_ONE - WGT_W'(w_hu);
                r_wm <= WGT_W'(w_hu) - WGT_W'(w_cu);
                r_w2 <= WGT_W'(w_cu);
            end else begin
                r_w0 <= WGT_ONE - WGT_W'(w_cu);
                r_wm <= WGT_W'(w_cu) - WGT_W'(w_hu);
                r_w2 <= WGT_W'(w_hu);
            end
        end
    end

    assign o_ctl   = r_ctl;
    assign o_h0    = r_h0;
    assign o_h1    = r_h1;
    assign o_c0    = r_c0;
    assign o_c1    = r_c1;
    assign o_w0    = r_w0;
    assign o_wm    = r_wm;
    assign o_w2    = r_w2;
    assign o_wdata = r_wdata;

endmodule

// ===== src/mgxy_blend.sv =====
// Blend stages: weight products, then sum, round and output register
module mgxy_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_lower,
    input  logic [mgxy_pkg::WGT_W-1:0]    i_w0,
    input  logic [mgxy_pkg::WGT_W-1:0]    i_wm,
    input  logic [mgxy_pkg::WGT_W-1:0]    i_w2,
    input  logic [mgxy_pkg::ENTRY_W-1:0]  i_e0,
    input  logic [mgxy_pkg::ENTRY_W-1:0]  i_e1,
    input  logic [mgxy_pkg::ENTRY_W-1:0]  i_e2,
    input  logic [mgxy_pkg::ENTRY_W-1:0]  i_e3,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mgxy_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import mgxy_pkg::*;

    logic [ENTRY_W-1:0] w_em;
    logic               w_adv3;
    logic               w_adv4;
    logic [SUM_W-1:0]   w_sx;
    logic [SUM_W-1:0]   w_sy;

    logic               r_v3;
    logic [PROD_W-1:0]  r_px0;
    logic [PROD_W-1:0]  r_pxm;
    logic [PROD_W-1:0]  r_px2;
    logic [PROD_W-1:0]  r_py0;
    logic [PROD_W-1:0]  r_pym;
    logic [PROD_W-1:0]  r_py2;
    logic               r_v4;
    logic [FRAC_W-1:0]  r_x;
    logic [FRAC_W-1:0]  r_y;

    // stage handshakes
    assign w_adv4  = !r_v4 || i_m_tready;
    assign w_adv3  = !r_v3 || w_adv4;
    assign o_ready = w_adv3;

    // middle corner: hue neighbor for lower triangle, chroma neighbor for upper
    assign w_em = i_lower ? i_e1 : i_e3;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv3) begin
                r_v3 <= i_valid;
            end
            if (w_adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // multiply weights by corner values
    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_px0 <= PROD_W'(i_w0) * PROD_W'(i_e0[FRAC_W-1:0]);
            r_pxm <= PROD_W'(i_wm) * PROD_W'(w_em[FRAC_W-1:0]);
            r_px2 <= PROD_W'(i_w2) * PROD_W'(i_e2[FRAC_W-1:0]);
            r_py0 <= PROD_W'(i_w0) * PROD_W'(i_e0[ENTRY_W-1:FRAC_W]);
            r_pym <= PROD_W'(i_wm) * PROD_W'(w_em[ENTRY_W-1:FRAC_W]);
            r_py2 <= PROD_W'(i_w2) * PROD_W'(i_e2[ENTRY_W-1:FRAC_W]);
        end
    end

    // sum and round half up
    assign w_sx = SUM_W'(r_px0) + SUM_W'(r_pxm) + SUM_W'(r_px2) + ROUND_HALF;
    assign w_sy = SUM_W'(r_py0) + SUM_W'(r_pym) + SUM_W'(r_py2) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_x <= w_sx[2*FRAC_W-1:FRAC_W];
            r_y <= w_sy[2*FRAC_W-1:FRAC_W];
        end
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {r_y, r_x};

endmodule

// ===== src/munsell_grid_to_xy_interp_unit.sv =====
// Top level of the hue-by-chroma xy grid with triangle interpolation
//
//  channel | dir | tdata fields (low bit up)                       | tuser
//  --------+-----+-------------------------------------------------+---------------
//  s       | in  | load_hue_index, load_chroma_index, load_x,      | cmd (0 load,
//          |     | load_y, hue, chroma, zero pad to 80             |      1 convert)
//  m       | out | x_out, y_out                                    | -
//
// One word per cycle in either kind while the output does not stall. A convert
// word is registered after index scaling, grid read, weight products and sum.
// A load word writes the grid as it leaves the index stage and gives no result.
// The four cell corners come from two grid copies with two read ports each.
// Reset clears only the stage control bits; grid content is undefined until loaded.
// Each stage advances when the next one is empty or draining, so a stall
// at the output fills bubbles before it reaches o_s_tready.
`include "munsell_grid_to_xy_interp_unit_assert.svh"

module munsell_grid_to_xy_interp_unit #(
    parameter int HUE_STEPS    = mgxy_pkg::HUE_STEPS_DEF,
    parameter int CHROMA_STEPS = mgxy_pkg::CHROMA_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // load_hue_index[5:0], load_chroma_index[10:6], load_x[26:11],
    // load_y[42:27], hue[58:43], chroma[74:59], zero [79:75]
    input  logic [mgxy_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // cmd[0]
    input  logic [mgxy_pkg::CMD_W-1:0]      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // x_out[15:0], y_out[31:16]
    output logic [mgxy_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import mgxy_pkg::*;

    localparam int HW    = $clog2(HUE_STEPS);
    localparam int CW    = $clog2(CHROMA_STEPS);
    localparam int DEPTH = HUE_STEPS * CHROMA_STEPS;
    localparam int AW    = $clog2(DEPTH);

    t_s1_ctl            w_ctl;
    logic [HW-1:0]      w_h0;
    logic [HW-1:0]      w_h1;
    logic [CW-1:0]      w_c0;
    logic [CW-1:0]      w_c1;
    logic [WGT_W-1:0]   w_w0;
    logic [WGT_W-1:0]   w_wm;
    logic [WGT_W-1:0]   w_w2;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_adv2;
    logic               w_rdy3;
    logic               w_we;
    logic [AW-1:0]      w_a00;
    logic [AW-1:0]      w_a10;
    logic [AW-1:0]      w_a11;
    logic [AW-1:0]      w_a01;
    logic [ENTRY_W-1:0] w_e0;
    logic [ENTRY_W-1:0] w_e1;
    logic [ENTRY_W-1:0] w_e2;
    logic [ENTRY_W-1:0] w_e3;

    logic               r_v2;
    logic               r_lower2;
    logic [WGT_W-1:0]   r_w0;
    logic [WGT_W-1:0]   r_wm;
    logic [WGT_W-1:0]   r_w2;

    // scale, wrap and clamp
    mgxy_index #(
        .HUE_STEPS    (HUE_STEPS),
        .CHROMA_STEPS (CHROMA_STEPS),
        .HW           (HW),
        .CW           (CW)
    ) u_index (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_s_tvalid),
        .o_ready             (o_s_tready),
        .i_cmd               (i_s_tuser),
        .i_load_hue_index    (i_s_tdata[5:0]),
        .i_load_chroma_index (i_s_tdata[10:6]),
        .i_load_x            (i_s_tdata[26:11]),
        .i_load_y            (i_s_tdata[42:27]),
        .i_hue               (i_s_tdata[58:43]),
        .i_chroma            (i_s_tdata[74:59]),
        .i_ready             (w_adv2),
        .o_ctl               (w_ctl),
        .o_h0                (w_h0),
        .o_h1                (w_h1),
        .o_c0                (w_c0),
        .o_c1                (w_c1),
        .o_w0                (w_w0),
        .o_wm                (w_wm),
        .o_w2                (w_w2),
        .o_wdata             (w_wdata)
    );

    // corner addresses, row major
    assign w_a00 = AW'(32'(w_h0) * 32'(CHROMA_STEPS) + 32'(w_c0));
    assign w_a10 = AW'(32'(w_h1) * 32'(CHROMA_STEPS) + 32'(w_c0));
    assign w_a11 = AW'(32'(w_h1) * 32'(CHROMA_STEPS) + 32'(w_c1));
    assign w_a01 = AW'(32'(w_h0) * 32'(CHROMA_STEPS) + 32'(w_c1));

    // grid read stage advances into an empty or draining blend stage
    assign w_adv2 = !r_v2 || w_rdy3;
    // write both copies as the load word leaves the index stage
    assign w_we   = w_ctl.valid && w_ctl.load && w_ctl.in_range && w_adv2;

    // copy A serves the base and far corners
    mgxy_grid_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_a00),
        .i_wdata   (w_wdata),
        .i_re      (w_adv2),
        .i_raddr_a (w_a00),
        .i_raddr_b (w_a11),
        .o_rdata_a (w_e0),
        .o_rdata_b (w_e2)
    );

    // copy B serves the hue neighbor and chroma neighbor corners
    mgxy_grid_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_a00),
        .i_wdata   (w_wdata),
        .i_re      (w_adv2),
        .i_raddr_a (w_a10),
        .i_raddr_b (w_a01),
        .o_rdata_a (w_e1),
        .o_rdata_b (w_e3)
    );

    // carry convert words alongside the read; drop load words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= w_ctl.valid && !w_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_lower2 <= w_ctl.lower;
            r_w0     <= w_w0;
            r_wm     <= w_wm;
            r_w2     <= w_w2;
        end
    end

    // weight, sum and present the result
    mgxy_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .o_ready    (w_rdy3),
        .i_lower    (r_lower2),
        .i_w0       (r_w0),
        .i_wm       (r_wm),
        .i_w2       (r_w2),
        .i_e0       (w_e0),
        .i_e1       (w_e1),
        .i_e2       (w_e2),
        .i_e3       (w_e3),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    `MGXY_ASSERT_NEXT(a_load_no_result, w_ctl.valid && w_ctl.load && w_adv2, !r_v2, "load word reached the read stage")
    `MGXY_ASSERT_NEXT(a_read_hold, r_v2 && !w_rdy3, r_v2 && $stable(w_e0) && $stable(w_e1) && $stable(w_e2) && $stable(w_e3), "grid read data changed while stalled")
    `MGXY_ASSERT_SAME(a_stall_full, !o_s_tready, w_ctl.valid && r_v2 && o_m_tvalid, "input stalled with a free stage")
    `MGXY_ASSERT_SAME(a_write_only_load, w_we, w_ctl.load && w_ctl.valid, "grid written by a convert word")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the hue-by-chroma xy grid interpolation unit
module tb;
    import mgxy_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int GRID_ROWS  = HUE_STEPS_DEF;
    localparam int GRID_COLS  = CHROMA_STEPS_DEF;
    localparam int GRID_DEPTH = GRID_ROWS * GRID_COLS;
    localparam int DRAIN_WAIT = 8;
    localparam int MAX_SHOWN  = 10;

    // one stream word, lowest field first from the bottom up
    typedef struct packed {
        logic [FRAC_W-1:0]   chroma;
        logic [FRAC_W-1:0]   hue;
        logic [FRAC_W-1:0]   ld_y;
        logic [FRAC_W-1:0]   ld_x;
        logic [LD_CHR_W-1:0] ld_chr;
        logic [LD_HUE_W-1:0] ld_hue;
    } t_grid_word;

    localparam int WORD_W = $bits(t_grid_word);

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // load_hue_index, load_chroma_index, load_x, load_y, hue, chroma, zero pad
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    // cmd
    logic [CMD_W-1:0]      i_s_tuser  = CMD_LOAD;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // x_out, y_out
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // grid copy of the predictor: y in the upper half, x in the lower half
    logic [ENTRY_W-1:0]    grid_xy [GRID_DEPTH];
    // interpolated {y, x} words still to come out
    logic [OUT_DATA_W-1:0] expected_xy [$];
    int                    xy_errors       = 0;
    int                    tx_idle_pct     = 0;
    int                    rx_idle_pct     = 0;
    int                    rx_hold_request = 0;

    munsell_grid_to_xy_interp_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // rounded barycentric blend of three u0.16 values, weights in u1.16
    function automatic logic [FRAC_W-1:0] blend_round(
        logic [WGT_W-1:0] wa, logic [FRAC_W-1:0] va,
        logic [WGT_W-1:0] wb, logic [FRAC_W-1:0] vb,
        logic [WGT_W-1:0] wc, logic [FRAC_W-1:0] vc);
        logic [35:0] acc;
        acc = 36'(wa) * va + 36'(wb) * vb + 36'(wc) * vc + 36'd32768;
        return acc[31:16];
    endfunction

    // update the grid copy or queue the interpolated xy of one accepted word
    function automatic void predict_grid_word(logic [CMD_W-1:0] kind, t_grid_word w);
        int unsigned      hs, cs, h0, h1, c0, c1, hu, cu;
        logic [ENTRY_W-1:0] e0, e2, e_mid;
        logic [WGT_W-1:0] wa, wb, wc;
        logic [FRAC_W-1:0] px, py;
        if (kind == CMD_LOAD) begin
            // drop loads that fall outside the grid
            if (w.ld_hue < GRID_ROWS && w.ld_chr < GRID_COLS)
                grid_xy[w.ld_hue * GRID_COLS + w.ld_chr] = {w.ld_y, w.ld_x};
            return;
        end
        hs = w.hue * GRID_ROWS;
        cs = w.chroma * GRID_COLS;
        h0 = hs >> FRAC_W;
        c0 = cs >> FRAC_W;
        hu = hs & 32'hFFFF;
        cu = cs & 32'hFFFF;
        // hue wraps to row zero, chroma sticks at the last column
        h1 = (h0 + 1 >= GRID_ROWS) ? 0 : h0 + 1;
        c1 = (c0 + 1 >= GRID_COLS) ? GRID_COLS - 1 : c0 + 1;
        e0 = grid_xy[h0 * GRID_COLS + c0];
        e2 = grid_xy[h1 * GRID_COLS + c1];
        if (hu >= cu) begin
            e_mid = grid_xy[h1 * GRID_COLS + c0];
            wa = WGT_ONE - WGT_W'(hu);
            wb = WGT_W'(hu - cu);
            wc = WGT_W'(cu);
        end else begin
            e_mid = grid_xy[h0 * GRID_COLS + c1];
            wa = WGT_ONE - WGT_W'(cu);
            wb = WGT_W'(cu - hu);
            wc = WGT_W'(hu);
        end
        px = blend_round(wa, e0[15:0], wb, e_mid[15:0], wc, e2[15:0]);
        py = blend_round(wa, e0[31:16], wb, e_mid[31:16], wc, e2[31:16]);
        expected_xy.push_back({py, px});
    endfunction

    // u0.16 value with a bias toward both ends of the range
    function automatic logic [FRAC_W-1:0] rand_frac();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return FRAC_W'($urandom);
    endfunction

    // offer one word, wait for the handshake, then predict it
    task automatic send_grid_word(input logic [CMD_W-1:0] kind, input t_grid_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_W'(w);
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        predict_grid_word(kind, w);
    endtask

    task automatic send_load(input logic [LD_HUE_W-1:0] h, input logic [LD_CHR_W-1:0] c,
                             input logic [FRAC_W-1:0] x, input logic [FRAC_W-1:0] y);
        t_grid_word w;
        w        = t_grid_word'(WORD_W'({$urandom, $urandom, $urandom}));
        w.ld_hue = h;
        w.ld_chr = c;
        w.ld_x   = x;
        w.ld_y   = y;
        send_grid_word(CMD_LOAD, w);
    endtask

    task automatic send_convert(input logic [FRAC_W-1:0] hue, input logic [FRAC_W-1:0] chroma);
        t_grid_word w;
        w        = t_grid_word'(WORD_W'({$urandom, $urandom, $urandom}));
        w.hue    = hue;
        w.chroma = chroma;
        send_grid_word(CMD_CONV, w);
    endtask

    // random convert; a few land on cell corners where both fractions are zero
    task automatic send_random_convert();
        if ($urandom_range(19) == 0)
            send_convert(FRAC_W'($urandom_range(7) * 8192), '0);
        else
            send_convert(rand_frac(), rand_frac());
    endtask

    // hold the input idle until every queued result has come out
    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_xy.size() != 0);
    endtask

    // cell corners, triangle choice, hue wrap, chroma clamp, dropped loads
    task automatic test_directed_corners();
        send_load(0, 0, 16'h0000, 16'hFFFF);
        send_load(1, 0, 16'hFFFF, 16'h0000);
        send_load(1, 1, 16'h1234, 16'hABCD);
        send_load(0, 1, 16'hFFFF, 16'hFFFF);
        send_load(39, 0, 16'h8000, 16'h7FFF);
        send_load(39, 1, 16'h0001, 16'hFFFE);
        send_load(0, 20, 16'hFFFF, 16'h0000);
        send_load(1, 20, 16'h0000, 16'hFFFF);
        send_load(39, 20, 16'h5555, 16'hAAAA);
        // loads beyond the grid must not alias onto real entries
        send_load(0, 21, 16'hFFFF, 16'hFFFF);
        send_load(40, 0, 16'hFFFF, 16'hFFFF);
        send_load(63, 31, 16'hFFFF, 16'hFFFF);
        send_convert(16'd0, 16'd0);
        send_convert(16'd1000, 16'd500);
        send_convert(16'd500, 16'd2000);
        // equal fractions take the lower triangle
        send_convert(16'd1050, 16'd2000);
        send_convert(16'hFFFF, 16'd0);
        send_convert(16'd0, 16'hFFFF);
        send_convert(16'hFFFF, 16'hFFFF);
    endtask

    // write every grid entry so any cell may be converted afterwards
    task automatic test_grid_fill();
        for (int h = 0; h < GRID_ROWS; h++)
            for (int c = 0; c < GRID_COLS; c++)
                send_load(LD_HUE_W'(h), LD_CHR_W'(c), rand_frac(), rand_frac());
    endtask

    // mostly converts, some grid rewrites, some loads outside the grid
    task automatic test_mixed_traffic(input int n_words);
        int unsigned pick;
        for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_random_convert();
            else if (pick < 90)
                send_load(LD_HUE_W'($urandom_range(GRID_ROWS - 1)),
                          LD_CHR_W'($urandom_range(GRID_COLS - 1)), rand_frac(), rand_frac());
            else
                send_load(LD_HUE_W'($urandom), LD_CHR_W'($urandom), rand_frac(), rand_frac());
        end
    endtask

    // long output stall while converts keep coming, so the input backs up
    task automatic test_output_backpressure();
        rx_hold_request = 300;
        for (int i = 0; i < 100; i++)
            send_random_convert();
    endtask

    // result side: random stalls plus requested long hold-offs
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_request > 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic note_xy_error(input string what, input logic [FRAC_W-1:0] want,
                                 input logic [FRAC_W-1:0] got);
        xy_errors++;
        if (xy_errors <= MAX_SHOWN)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    // compare each output word against the oldest prediction
    initial begin
        logic [OUT_DATA_W-1:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (expected_xy.size() == 0) begin
                    xy_errors++;
                    if (xy_errors <= MAX_SHOWN)
                        $display("%0t: unexpected result word %h", $realtime, o_m_tdata);
                end else begin
                    want = expected_xy.pop_front();
                    if (o_m_tdata[15:0] !== want[15:0])
                        note_xy_error("x_out", want[15:0], o_m_tdata[15:0]);
                    if (o_m_tdata[31:16] !== want[31:16])
                        note_xy_error("y_out", want[31:16], o_m_tdata[31:16]);
                end
            end
        end
    end

    // hard stop if the stream hangs
    initial begin
        #(CLK_PERIOD * 200000);
        $display("munsell_grid_to_xy_interp_unit verification failed");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        tx_idle_pct = 22;
        rx_idle_pct = 48;
        test_directed_corners();
        test_grid_fill();
        test_mixed_traffic(350);
        wait_results_drained();

        // swap the idle rates
        tx_idle_pct = 48;
        rx_idle_pct = 22;
        test_mixed_traffic(350);

        // full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_backpressure();
        test_mixed_traffic(350);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_xy.size() != 0)
            xy_errors++;
        if (xy_errors == 0)
            $display("munsell_grid_to_xy_interp_unit verification clean");
        else
            $display("munsell_grid_to_xy_interp_unit verification failed");
        $finish;
    end
endmodule

// ===== munsell_grid_to_xy_interp_unit.f =====
+incdir+src
src/mgxy_pkg.sv
src/mgxy_grid_ram.sv
src/mgxy_index.sv
src/mgxy_blend.sv
src/munsell_grid_to_xy_interp_unit.sv
verif/tb.sv
